FILE: rtl/ttp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_pkg
// Shared types and constants of the trapezoidal trajectory planner.
// ----------------------------------------------------------------------------
package ttp_pkg;

    // request kinds carried in req_type
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // register indexes on the configuration port (paddr[3:2])
    localparam logic [1:0] REG_MAX_VELOCITY     = 2'd0;
    localparam logic [1:0] REG_MAX_ACCELERATION = 2'd1;
    localparam logic [1:0] REG_TICK_PERIOD      = 2'd2;

    // register reset values
    localparam logic [30:0] MAX_VELOCITY_RESET     = 31'd65536;
    localparam logic [30:0] MAX_ACCELERATION_RESET = 31'd65536;
    localparam logic [23:0] TICK_PERIOD_RESET      = 24'd16777;

    // deadband around the target, 0.001 in Q16.16
    localparam int DEADBAND_RAW = 66;

    // half of one unit after the 24-bit shift, for round to nearest
    localparam logic [63:0] ROUND_HALF = 64'd1 << 23;

    // input word
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] position_value;
    } cmd_t;

    // output word
    typedef struct packed {
        logic signed [31:0] planned_position;
        logic signed [31:0] planned_velocity;
    } plan_t;

endpackage

FILE: rtl/trapezoidal_trajectory_planner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoidal_trajectory_planner_core
// Trapezoidal velocity profile: one update or load word per control tick,
// one planned position and velocity word back, built around one shared
// 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                         | payload
//  cmd     | in        | cmd_valid / cmd_ready             | cmd_t
//  plan    | out       | plan_valid / plan_ready           | plan_t
//  apb     | in        | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// An update word passes the sequencer steps ERR, DV, VSQ, AIM, VEL, STEP
// and POS after its accept cycle, a load word only POS; plan is registered in POS.
// The steps are set by the shared multiplier, which serves a*dt, v*v, 2a*|err|
// and v*dt in turn. cmd_ready is high only while the sequencer is idle, and
// the final step holds while an earlier result still waits on plan.
// Reset restores position, velocity and registers; no clearing pass.
// ----------------------------------------------------------------------------
module trapezoidal_trajectory_planner_core
    import ttp_pkg::*;
#(
    parameter int POS_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,

    output logic        plan_valid,
    input  logic        plan_ready,
    output plan_t       plan,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // widths of the wide position arithmetic
    localparam int PW_EXT = (POS_WIDTH > 32) ? POS_WIDTH : 32;
    localparam int EW     = PW_EXT + 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ERR  = 3'd1;
    localparam logic [2:0] ST_DV   = 3'd2;
    localparam logic [2:0] ST_VSQ  = 3'd3;
    localparam logic [2:0] ST_AIM  = 3'd4;
    localparam logic [2:0] ST_VEL  = 3'd5;
    localparam logic [2:0] ST_STEP = 3'd6;
    localparam logic [2:0] ST_POS  = 3'd7;

    // configuration registers
    logic [30:0] max_velocity_reg;
    logic [30:0] max_acceleration_reg;
    logic [23:0] tick_period_reg;

    // planner state
    logic signed [POS_WIDTH-1:0] pos_reg;
    logic signed [31:0]          vel_reg;

    // sequencer and per-word working registers
    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic                        req_reg;
    logic signed [31:0]          pv_reg;
    logic                        err_neg_reg;
    logic                        err_hi_nz_reg;
    logic [31:0]                 err_lo_reg;
    logic                        dead_reg;
    logic signed [POS_WIDTH-1:0] base_reg;
    logic [31:0]                 dv_reg;
    logic [63:0]                 vsq_reg;
    logic signed [31:0]          aim_reg;
    logic signed [31:0]          vel_new_reg;
    logic [63:0]                 product_reg;

    // output register
    logic  plan_valid_reg;
    plan_t plan_reg;

    logic cfg_write;
    logic cmd_fire;
    logic out_free;

    // apb access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_VELOCITY:     prdata = {1'b0, max_velocity_reg};
            REG_MAX_ACCELERATION: prdata = {1'b0, max_acceleration_reg};
            REG_TICK_PERIOD:      prdata = {8'd0, tick_period_reg};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_velocity_reg     <= MAX_VELOCITY_RESET;
            max_acceleration_reg <= MAX_ACCELERATION_RESET;
            tick_period_reg      <= TICK_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_MAX_VELOCITY:     max_velocity_reg     <= pwdata[30:0];
                REG_MAX_ACCELERATION: max_acceleration_reg <= pwdata[30:0];
                REG_TICK_PERIOD:      tick_period_reg      <= pwdata[23:0];
                default:              ;
            endcase
        end
    end

    // handshakes
    assign cmd_ready  = (state_reg == ST_IDLE);
    assign cmd_fire   = cmd_valid && cmd_ready;
    assign out_free   = !plan_valid_reg || plan_ready;
    assign plan_valid = plan_valid_reg;
    assign plan       = plan_reg;

    // sign extensions of the stored values
    logic signed [EW-1:0] pv_ext;
    logic signed [EW-1:0] pos_ext;
    logic signed [EW-1:0] base_ext;

    assign pv_ext   = {{(EW-32){pv_reg[31]}}, pv_reg};
    assign pos_ext  = {{(EW-POS_WIDTH){pos_reg[POS_WIDTH-1]}}, pos_reg};
    assign base_ext = {{(EW-POS_WIDTH){base_reg[POS_WIDTH-1]}}, base_reg};

    // error to target and its magnitude
    logic signed [EW-1:0] err;
    logic [EW-1:0]        aerr;

    assign err  = pv_ext - pos_ext;
    assign aerr = err[EW-1] ? EW'(-err) : EW'(err);

    // shared multiplier operands
    logic [31:0] mult_a;
    logic [31:0] mult_b;
    logic signed [31:0] vmag_src;
    logic [31:0] vmag;

    assign vmag_src = (state_reg == ST_STEP) ? vel_new_reg : vel_reg;
    assign vmag     = vmag_src[31] ? 32'(-vmag_src) : 32'(vmag_src);

    always_comb
    begin
        case (state_reg)
            ST_ERR:
            begin
                mult_a = {1'b0, max_acceleration_reg};
                mult_b = {8'd0, tick_period_reg};
            end
            ST_DV:
            begin
                mult_a = vmag;
                mult_b = vmag;
            end
            ST_VSQ:
            begin
                mult_a = {max_acceleration_reg, 1'b0};
                mult_b = err_lo_reg;
            end
            ST_STEP:
            begin
                mult_a = vmag;
                mult_b = {8'd0, tick_period_reg};
            end
            default:
            begin
                mult_a = 32'd0;
                mult_b = 32'd0;
            end
        endcase
    end

    // rounded product >> 24 (dv and position step magnitude)
    logic [63:0] prod_round;
    logic [31:0] prod_q;

    assign prod_round = product_reg + ROUND_HALF;
    assign prod_q     = prod_round[55:24];

    // position step and new position before saturation
    logic signed [31:0]   step;
    logic signed [EW-1:0] pos_sum;

    assign step    = vel_new_reg[31] ? 32'(-prod_q) : 32'(prod_q);
    assign pos_sum = base_ext + {{(EW-32){step[31]}}, step};

    // shared position saturation
    logic signed [EW-1:0]        sat_in;
    logic signed [POS_WIDTH-1:0] sat_out;
    logic                        sat_ok;

    assign sat_in  = ((state_reg == ST_POS) && (req_reg == REQ_UPDATE)) ? pos_sum : pv_ext;
    assign sat_ok  = (&sat_in[EW-1:POS_WIDTH-1]) || !(|sat_in[EW-1:POS_WIDTH-1]);
    assign sat_out = sat_ok ? sat_in[POS_WIDTH-1:0]
                            : {sat_in[EW-1], {(POS_WIDTH-1){~sat_in[EW-1]}}};

    // braking test and aim velocity
    logic                toward;
    logic                brake;
    logic signed [31:0]  aim;

    assign toward = err_neg_reg ? vel_reg[31] : (!vel_reg[31] && (vel_reg != 32'sd0));
    assign brake  = toward
                    && !((max_acceleration_reg != 31'd0) && err_hi_nz_reg)
                    && (vsq_reg >= product_reg);

    always_comb
    begin
        if (dead_reg || brake)
            aim = 32'sd0;
        else if (err_neg_reg)
            aim = -$signed({1'b0, max_velocity_reg});
        else
            aim = $signed({1'b0, max_velocity_reg});
    end

    // velocity step toward the aim, limited by dv
    logic signed [33:0] vel_w;
    logic signed [33:0] aim_w;
    logic signed [33:0] dv_w;
    logic signed [33:0] verr;
    logic signed [33:0] vel_sum;
    logic signed [31:0] vel_sat;

    assign vel_w = {{2{vel_reg[31]}}, vel_reg};
    assign aim_w = {{2{aim_reg[31]}}, aim_reg};
    assign dv_w  = {2'b00, dv_reg};
    assign verr  = aim_w - vel_w;

    always_comb
    begin
        if (verr > dv_w)
            vel_sum = vel_w + dv_w;
        else if (verr < -dv_w)
            vel_sum = vel_w - dv_w;
        else
            vel_sum = aim_w;
    end

    assign vel_sat = ((&vel_sum[33:31]) || !(|vel_sum[33:31])) ? vel_sum[31:0]
                     : {vel_sum[33], {31{~vel_sum[33]}}};

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                    state_next = (cmd.req_type == REQ_LOAD) ? ST_POS : ST_ERR;
            end
            ST_ERR:  state_next = ST_DV;
            ST_DV:   state_next = ST_VSQ;
            ST_VSQ:  state_next = ST_AIM;
            ST_AIM:  state_next = ST_VEL;
            ST_VEL:  state_next = ST_STEP;
            ST_STEP: state_next = ST_POS;
            ST_POS:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            plan_valid_reg <= 1'b0;
            pos_reg        <= '0;
            vel_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_POS) && out_free)
            begin
                plan_valid_reg <= 1'b1;
                pos_reg        <= sat_out;
                vel_reg        <= (req_reg == REQ_LOAD) ? 32'sd0 : vel_new_reg;
            end
            else if (plan_ready)
            begin
                plan_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    logic signed [EW-1:0] out_pos_ext;

    assign out_pos_ext = {{(EW-POS_WIDTH){sat_out[POS_WIDTH-1]}}, sat_out};

    always_ff @(posedge clk)
    begin
        // product of the step stays put while the last step waits
        if (state_reg != ST_POS)
            product_reg <= mult_a * mult_b;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    req_reg <= cmd.req_type;
                    pv_reg  <= cmd.position_value;
                end
            end
            ST_ERR:
            begin
                err_neg_reg   <= err[EW-1];
                err_hi_nz_reg <= |aerr[EW-1:32];
                err_lo_reg    <= aerr[31:0];
                dead_reg      <= (aerr < EW'(DEADBAND_RAW));
                base_reg      <= (aerr < EW'(DEADBAND_RAW)) ? sat_out : pos_reg;
            end
            ST_DV:   dv_reg      <= prod_q;
            ST_VSQ:  vsq_reg     <= product_reg;
            ST_AIM:  aim_reg     <= aim;
            ST_VEL:  vel_new_reg <= vel_sat;
            ST_POS:
            begin
                if (out_free)
                begin
                    plan_reg.planned_position <= out_pos_ext[31:0];
                    plan_reg.planned_velocity <= (req_reg == REQ_LOAD) ? 32'sd0 : vel_new_reg;
                end
            end
            default: ;
        endcase
    end

endmodule
